/* hw/rtl/ree_pkg.sv */
// shared types, byte codes and class string table for the class escape expander
package ree_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_CARET   = 8'h5e;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_UPPER_D = 8'h44;

    // class selector: bit 0 = negated, bit 1 = digit (else space)
    localparam logic [1:0] SEL_SPACE  = 2'd0;
    localparam logic [1:0] SEL_NSPACE = 2'd1;
    localparam logic [1:0] SEL_DIGIT  = 2'd2;
    localparam logic [1:0] SEL_NDIGIT = 2'd3;

    localparam logic [3:0] LEN_CLASS     = 4'd11;
    localparam logic [3:0] LEN_CLASS_NEG = 4'd12;

    localparam logic [7:0] NAME_SPACE [5] = '{8'h73, 8'h70, 8'h61, 8'h63, 8'h65};
    localparam logic [7:0] NAME_DIGIT [5] = '{8'h64, 8'h69, 8'h67, 8'h69, 8'h74};

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_PAIR,
        ACT_CLASS
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        logic [7:0] data;
        logic [1:0] sel;
    } act_t;

    localparam int ACT_W = $bits(act_t);

    // byte idx of the class string picked by sel
    function automatic logic [7:0] class_char(logic [1:0] sel, logic [3:0] idx);
        logic [3:0] j;
        logic [7:0] c;
        j = (sel[0] && idx >= 4'd2) ? idx - 4'd1 : idx;
        case (j)
            4'd0, 4'd1: c = CH_LBRACK;
            4'd2, 4'd8: c = CH_COLON;
            4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
                c = sel[1] ? NAME_DIGIT[3'(j - 4'd3)] : NAME_SPACE[3'(j - 4'd3)];
            end
            default: c = CH_RBRACK;
        endcase
        if (sel[0] && idx == 4'd1) begin
            c = CH_CARET;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/ree_front.sv */
// front end: scans input bytes, tracks bracket state, issues emit actions
module ree_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ree_pkg::in_item_t s_data,
    input  logic              newline_at_end,
    input  logic              q_full,
    output logic              push,
    output ree_pkg::act_t     act
);

    typedef enum logic [2:0] {
        MODE_PLAIN       = 3'd0,
        MODE_BACKSLASH   = 3'd1,
        MODE_OPENED      = 3'd2,
        MODE_INNER_OPEN  = 3'd3,
        MODE_CLASS_NAME  = 3'd4,
        MODE_CLASS_CLOSE = 3'd5
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  in_br_reg, in_br_next;
    logic  has_content_reg, has_content_next;
    logic  act_valid;
    logic  accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && act_valid;

    always_comb begin
        logic [7:0] b;
        logic       do_plain;
        b                = s_data.in_byte;
        do_plain         = 1'b0;
        mode_next        = mode_reg;
        in_br_next       = in_br_reg;
        has_content_next = has_content_reg;
        act_valid        = 1'b1;
        act.kind         = ree_pkg::ACT_BYTE;
        act.data         = b;
        act.sel          = ree_pkg::SEL_SPACE;
        if (s_data.op) begin
            mode_next        = MODE_PLAIN;
            in_br_next       = 1'b0;
            has_content_next = 1'b0;
            if (mode_reg == MODE_BACKSLASH) begin
                if (newline_at_end) begin
                    act.kind = ree_pkg::ACT_PAIR;
                    act.data = ree_pkg::CH_NEWLINE;
                end else begin
                    act.data = ree_pkg::CH_BSLASH;
                end
            end else begin
                act.data  = ree_pkg::CH_NEWLINE;
                act_valid = newline_at_end;
            end
        end else begin
            case (mode_reg)
                MODE_BACKSLASH: begin
                    mode_next = MODE_PLAIN;
                    act.kind  = ree_pkg::ACT_CLASS;
                    if (b == ree_pkg::CH_LOWER_S) begin
                        act.sel = ree_pkg::SEL_SPACE;
                    end else if (b == ree_pkg::CH_UPPER_S) begin
                        act.sel = ree_pkg::SEL_NSPACE;
                    end else if (b == ree_pkg::CH_LOWER_D) begin
                        act.sel = ree_pkg::SEL_DIGIT;
                    end else if (b == ree_pkg::CH_UPPER_D) begin
                        act.sel = ree_pkg::SEL_NDIGIT;
                    end else begin
                        act.kind = ree_pkg::ACT_PAIR;
                    end
                end
                MODE_OPENED: begin
                    mode_next = MODE_PLAIN;
                    do_plain  = (b != ree_pkg::CH_CARET);
                end
                MODE_INNER_OPEN: begin
                    if (b == ree_pkg::CH_COLON) begin
                        mode_next = MODE_CLASS_NAME;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                MODE_CLASS_NAME: begin
                    if (b == ree_pkg::CH_COLON) begin
                        mode_next = MODE_CLASS_CLOSE;
                    end else if (b < ree_pkg::CH_LOWER_A || b > ree_pkg::CH_LOWER_Z) begin
                        do_plain = 1'b1;
                    end
                end
                MODE_CLASS_CLOSE: begin
                    mode_next = MODE_PLAIN;
                    do_plain  = (b != ree_pkg::CH_RBRACK);
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase
            // byte handled as ordinary text, also after a failed lookahead
            if (do_plain) begin
                mode_next = MODE_PLAIN;
                if (b == ree_pkg::CH_BSLASH) begin
                    if (!in_br_reg) begin
                        mode_next = MODE_BACKSLASH;
                        act_valid = 1'b0;
                    end else begin
                        has_content_next = 1'b1;
                    end
                end else if (b == ree_pkg::CH_LBRACK) begin
                    if (!in_br_reg) begin
                        in_br_next = 1'b1;
                        mode_next  = MODE_OPENED;
                    end else begin
                        has_content_next = 1'b1;
                        mode_next        = MODE_INNER_OPEN;
                    end
                end else if (b == ree_pkg::CH_RBRACK) begin
                    if (in_br_reg) begin
                        if (has_content_reg) begin
                            in_br_next       = 1'b0;
                            has_content_next = 1'b0;
                        end else begin
                            has_content_next = 1'b1;
                        end
                    end
                end else if (in_br_reg) begin
                    has_content_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_PLAIN;
            in_br_reg       <= 1'b0;
            has_content_reg <= 1'b0;
        end else if (accept) begin
            mode_reg        <= mode_next;
            in_br_reg       <= in_br_next;
            has_content_reg <= has_content_next;
        end
    end

`ifndef ASSERT_OFF
    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.op |=> mode_reg == MODE_PLAIN && !in_br_reg && !has_content_reg)
        else $error("state not cleared after end transfer");
    a_content_needs_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        has_content_reg |-> in_br_reg)
        else $error("bracket content flag set outside a bracket");
`endif

endmodule

/* hw/rtl/ree_queue.sv */
// small action queue between the front end and the emitter
module ree_queue #(
    parameter int DEPTH = ree_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ree_pkg::act_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ree_pkg::act_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ree_pkg::act_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/ree_back.sv */
// emitter: expands queued actions into result bytes, one per cycle while the receiver takes them
module ree_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ree_pkg::act_t      q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ree_pkg::out_item_t m_data
);

    logic [3:0]         idx_reg;
    logic               m_valid_reg;
    ree_pkg::out_item_t m_data_reg;
    logic [3:0]         run_len;
    logic [7:0]         cur_byte;
    logic               cur_last;
    logic               load;

    always_comb begin
        case (q_data.kind)
            ree_pkg::ACT_BYTE: begin
                run_len  = 4'd1;
                cur_byte = q_data.data;
            end
            ree_pkg::ACT_PAIR: begin
                run_len  = 4'd2;
                cur_byte = (idx_reg == 4'd0) ? ree_pkg::CH_BSLASH : q_data.data;
            end
            ree_pkg::ACT_CLASS: begin
                run_len  = q_data.sel[0] ? ree_pkg::LEN_CLASS_NEG : ree_pkg::LEN_CLASS;
                cur_byte = ree_pkg::class_char(q_data.sel, idx_reg);
            end
            default: begin
                run_len  = 4'd1;
                cur_byte = q_data.data;
            end
        endcase
    end

    assign cur_last = (idx_reg == run_len - 4'd1);
    assign load     = q_valid && (!m_valid_reg || m_ready);
    assign pop      = load && cur_last;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_byte    <= cur_byte;
            m_data_reg.last_of_run <= cur_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= cur_last ? 4'd0 : idx_reg + 4'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_run_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 4'd0 |-> q_valid)
        else $error("run in progress without a queued action");
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> idx_reg < run_len)
        else $error("byte index past end of run");
`endif

endmodule

/* hw/rtl/regex_class_escape_expander.sv */
// top level of the regular-expression class escape expander
//
// usage
// - s_ channel: one pattern byte per transfer (op = 0), or an end marker (op = 1)
//   that flushes a pending backslash and optionally a newline
// - m_ channel: rewritten bytes, last_of_run set on the final byte of the run
//   caused by one input transfer; inputs that cause nothing give no transfer
// - apb port: register 0 (address 0) bit 0 = newline_at_end; write only while idle
// - path: each action is written into the queue, then its first result byte
//   into the output register
// - throughput: one result byte per cycle from the emitter while the receiver is
//   ready; an input causes 1, 2, 11 or 12 result bytes and holds the emitter until
//   its last one is out, so plain text streams at one byte per cycle and class
//   expansions back-pressure s_ready once the two-entry action queue fills
// - receiver stall: the output register holds its byte, the emitter and queue
//   stop, and s_ready drops when the queue is full; nothing is lost
// - reset (aresetn low, synchronous): scan state back to plain text outside any
//   bracket, queue and output emptied, newline_at_end cleared
module regex_class_escape_expander #(
    parameter int QUEUE_DEPTH = ree_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ree_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ree_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic          newline_at_end_reg;
    logic          reg_hit;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    ree_pkg::act_t front_act;
    ree_pkg::act_t q_head;

    // register file: a single control bit at byte address 0, decoded from paddr[2] only
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {31'b0, newline_at_end_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newline_at_end_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            newline_at_end_reg <= pwdata[0];
        end
    end

    // front end classifies each transfer and issues at most one action
    ree_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .newline_at_end (newline_at_end_reg),
        .q_full         (q_full),
        .push           (q_push),
        .act            (front_act)
    );

    // decouples scanning from expansion so each side stalls on its own
    ree_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (front_act),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_head)
    );

    // emitter walks the action one byte per cycle into the output register, unless the receiver stalls
    ree_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/regex_class_escape_expander_tb.sv */
// testbench for the regex class escape expander: directed and random patterns, byte-level checks
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // item kinds on the input channel
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // register map: index 0 at byte addresses 0 to 3 (paddr[2] low), addresses 4 to 7 are unmapped
    localparam logic [2:0] ADDR_NEWLINE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    localparam int RUN_MAX      = 12;      // longest run one input can cause
    localparam int DRAIN_CYCLES = 8;       // queue stage plus output register, with margin
    localparam int CYCLE_LIMIT  = 400000;  // several times the slowest legal run
    localparam int LONG_HOLD    = 300;     // receiver hold-off for the backpressure test

    // scan state of the prediction, one code per construct being tracked
    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESCAPE,
        SCAN_OPENED,
        SCAN_INNER_OPEN,
        SCAN_CLASS_NAME,
        SCAN_CLASS_CLOSE
    } scan_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ree_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    ree_pkg::out_item_t m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // prediction state, mirrors what the block should hold
    scan_t              scan_mode;
    bit                 in_bracket;
    bit                 bracket_filled;
    bit                 newline_on;
    logic [7:0]         run_bytes[$];
    ree_pkg::out_item_t pending_bytes[$];

    // stimulus controls and run statistics
    bit          src_gaps;
    bit          sink_gaps;
    int          hold_request = 0;
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_results = 0;
    int          n_expansions = 0;
    int          n_ends = 0;
    int          n_input_stalls = 0;
    int          cycle_count = 0;

    regex_class_escape_expander uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // free-running clock, 8 ns period
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop if the run hangs anywhere
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("regex_class_escape_expander: mismatch");
        $finish;
    end

    // only the first few errors get a line of their own
    function automatic void report_error(string what);
        n_errors++;
        if (n_errors <= 10) begin
            $display("error %0d at cycle %0d: %s", n_errors, cycle_count, what);
        end
    endfunction

    // ------------------------------------------------------------------
    // rewrite prediction
    // ------------------------------------------------------------------

    function automatic void emit(logic [7:0] b);
        if (run_bytes.size() < RUN_MAX) begin
            run_bytes.push_back(b);
        end
    endfunction

    function automatic void emit_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
        end
        n_expansions++;
    endfunction

    // ordinary byte handling, also the fall-back when a lookahead fails
    function automatic void plain_byte(logic [7:0] b);
        scan_mode = SCAN_TEXT;
        case (b)
            ree_pkg::CH_BSLASH: begin
                if (!in_bracket) begin
                    scan_mode = SCAN_ESCAPE;
                end else begin
                    emit(b);
                    bracket_filled = 1'b1;
                end
            end
            ree_pkg::CH_LBRACK: begin
                emit(b);
                if (!in_bracket) begin
                    in_bracket = 1'b1;
                    scan_mode  = SCAN_OPENED;
                end else begin
                    bracket_filled = 1'b1;
                    scan_mode      = SCAN_INNER_OPEN;
                end
            end
            ree_pkg::CH_RBRACK: begin
                emit(b);
                // a close bracket before any content is literal
                if (in_bracket) begin
                    if (bracket_filled) begin
                        in_bracket     = 1'b0;
                        bracket_filled = 1'b0;
                    end else begin
                        bracket_filled = 1'b1;
                    end
                end
            end
            default: begin
                emit(b);
                if (in_bracket) begin
                    bracket_filled = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void data_byte(logic [7:0] b);
        case (scan_mode)
            SCAN_ESCAPE: begin
                scan_mode = SCAN_TEXT;
                case (b)
                    ree_pkg::CH_LOWER_S: emit_text("[[:space:]]");
                    ree_pkg::CH_UPPER_S: emit_text("[^[:space:]]");
                    ree_pkg::CH_LOWER_D: emit_text("[[:digit:]]");
                    ree_pkg::CH_UPPER_D: emit_text("[^[:digit:]]");
                    default: begin
                        emit(ree_pkg::CH_BSLASH);
                        emit(b);
                    end
                endcase
            end
            SCAN_OPENED: begin
                scan_mode = SCAN_TEXT;
                if (b == ree_pkg::CH_CARET) begin
                    emit(b);
                end else begin
                    plain_byte(b);
                end
            end
            SCAN_INNER_OPEN: begin
                if (b == ree_pkg::CH_COLON) begin
                    emit(b);
                    scan_mode = SCAN_CLASS_NAME;
                end else begin
                    plain_byte(b);
                end
            end
            SCAN_CLASS_NAME: begin
                if (b >= ree_pkg::CH_LOWER_A && b <= ree_pkg::CH_LOWER_Z) begin
                    emit(b);
                end else if (b == ree_pkg::CH_COLON) begin
                    emit(b);
                    scan_mode = SCAN_CLASS_CLOSE;
                end else begin
                    plain_byte(b);
                end
            end
            SCAN_CLASS_CLOSE: begin
                scan_mode = SCAN_TEXT;
                if (b == ree_pkg::CH_RBRACK) begin
                    emit(b);
                end else begin
                    plain_byte(b);
                end
            end
            default: plain_byte(b);
        endcase
    endfunction

    // works out the run of bytes one accepted item causes and queues it
    function automatic void rewrite_item(ree_pkg::in_item_t it);
        ree_pkg::out_item_t r;
        run_bytes.delete();
        if (it.op == OP_DATA) begin
            data_byte(it.in_byte);
        end else begin
            // end marker: flush a dangling backslash, optional newline, fresh state
            if (scan_mode == SCAN_ESCAPE) begin
                emit(ree_pkg::CH_BSLASH);
            end
            if (newline_on) begin
                emit(ree_pkg::CH_NEWLINE);
            end
            scan_mode      = SCAN_TEXT;
            in_bracket     = 1'b0;
            bracket_filled = 1'b0;
            n_ends++;
        end
        foreach (run_bytes[i]) begin
            r.out_byte    = run_bytes[i];
            r.last_of_run = (i == run_bytes.size() - 1);
            pending_bytes.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking, sampled at the rising edge
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        ree_pkg::out_item_t want;
        if (aresetn && s_valid && !s_ready) begin
            n_input_stalls++;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_bytes.size() == 0) begin
                report_error($sformatf("unexpected result byte %02h last %0b",
                                       m_data.out_byte, m_data.last_of_run));
            end else begin
                want = pending_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte ||
                    m_data.last_of_run !== want.last_of_run) begin
                    report_error($sformatf(
                        "result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                        n_results, want.out_byte, want.last_of_run,
                        m_data.out_byte, m_data.last_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        int hold_left;
        m_ready    = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and register access, all called at a falling edge
    // ------------------------------------------------------------------

    // offers one item; valid stays high between back-to-back transfers
    task automatic send_item(ree_pkg::in_item_t it);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        rewrite_item(it);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b);
        ree_pkg::in_item_t it;
        it.op      = OP_DATA;
        it.in_byte = b;
        send_item(it);
    endtask

    // end marker with a junk byte that the block must ignore
    task automatic send_end();
        ree_pkg::in_item_t it;
        it.op      = OP_END;
        it.in_byte = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    // idle the input and let every queued result come out
    task automatic drain();
        s_valid = 1'b0;
        while (pending_bytes.size() != 0) @(negedge aclk);
        // end markers with no output may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_NEWLINE) begin
            newline_on = value[0];
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write the newline flag while idle and read it back
    task automatic set_newline(bit on);
        drain();
        reg_write(ADDR_NEWLINE, {31'd0, on});
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_NEWLINE;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== newline_on) begin
            report_error($sformatf("newline_at_end reads %0b, written %0b",
                                   prdata[0], newline_on));
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random pattern fragments, mostly well-formed with random content
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_text();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 5))
            0: return ree_pkg::CH_LOWER_S;
            1: return ree_pkg::CH_UPPER_S;
            2: return ree_pkg::CH_LOWER_D;
            3: return ree_pkg::CH_UPPER_D;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // [:name:] token, now and then broken by a stray byte or missing its close
    task automatic send_class_token();
        send_byte(ree_pkg::CH_LBRACK);
        send_byte(ree_pkg::CH_COLON);
        repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(ree_pkg::CH_LOWER_A, ree_pkg::CH_LOWER_Z)));
        end
        if ($urandom_range(0, 5) == 0) begin
            send_byte(pick_text());
        end
        send_byte(ree_pkg::CH_COLON);
        if ($urandom_range(0, 5) != 0) begin
            send_byte(ree_pkg::CH_RBRACK);
        end
    endtask

    task automatic send_bracket();
        send_byte(ree_pkg::CH_LBRACK);
        if ($urandom_range(0, 2) == 0) begin
            send_byte(ree_pkg::CH_CARET);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte(ree_pkg::CH_RBRACK);
        end
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 4))
                0: send_class_token();
                1: send_byte(ree_pkg::CH_BSLASH);
                2: send_byte(ree_pkg::CH_LBRACK);
                default: send_byte(pick_text());
            endcase
        end
        if ($urandom_range(0, 7) != 0) begin
            send_byte(ree_pkg::CH_RBRACK);
        end
    endtask

    task automatic send_fragment();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 4) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 10) begin
            send_byte(ree_pkg::CH_BSLASH);
            send_byte(pick_escape());
        end else if (kind < 17) begin
            send_bracket();
        end else if (kind < 19) begin
            send_byte(pick_text());
        end else begin
            send_end();
        end
    endtask

    task automatic send_random(int count);
        int start;
        start = n_sent;
        while (n_sent - start < count) begin
            send_fragment();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // the four class escapes and other escaped bytes at both ends of the range
    task automatic test_escapes();
        send_byte(ree_pkg::CH_BSLASH); send_byte(ree_pkg::CH_LOWER_S);
        send_byte(ree_pkg::CH_BSLASH); send_byte(ree_pkg::CH_UPPER_S);
        send_byte(ree_pkg::CH_BSLASH); send_byte(ree_pkg::CH_LOWER_D);
        send_byte(ree_pkg::CH_BSLASH); send_byte(ree_pkg::CH_UPPER_D);
        send_byte(ree_pkg::CH_BSLASH); send_byte(8'hff);
        send_byte(ree_pkg::CH_BSLASH); send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // leading caret, literal close bracket, literal backslash, class token
    task automatic test_brackets();
        send_byte(ree_pkg::CH_LBRACK);
        send_byte(ree_pkg::CH_CARET);
        send_byte(ree_pkg::CH_RBRACK);
        send_byte(ree_pkg::CH_BSLASH);
        send_byte(ree_pkg::CH_LBRACK);
        send_byte(ree_pkg::CH_COLON);
        send_byte(ree_pkg::CH_LOWER_A);
        send_byte(ree_pkg::CH_LOWER_Z);
        send_byte(ree_pkg::CH_COLON);
        send_byte(ree_pkg::CH_RBRACK);
        send_byte(ree_pkg::CH_RBRACK);
    endtask

    // end marker: backslash flush, silent end, newline on, unmapped write ignored
    task automatic test_end_marker();
        send_byte(ree_pkg::CH_BSLASH);
        send_end();
        send_end();
        set_newline(1'b1);
        drain();
        reg_write(ADDR_UNUSED, 32'h0);
        send_end();
        send_byte(ree_pkg::CH_BSLASH);
        send_end();
    endtask

    // random patterns over several register settings, with idling on both sides
    task automatic test_random_phases();
        set_newline(1'b0);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_random(60);
        set_newline(1'b1);
        src_gaps  = 1'b0;
        send_random(60);
        set_newline(1'($urandom_range(0, 1)));
        src_gaps  = 1'b1;
        sink_gaps = 1'b0;
        send_random(60);
    endtask

    // receiver holds off while escapes, mostly class expansions, keep coming, so s_ready must drop
    task automatic test_backpressure();
        src_gaps     = 1'b0;
        sink_gaps    = 1'b0;
        hold_request = LONG_HOLD;
        repeat (10) begin
            send_byte(ree_pkg::CH_BSLASH);
            send_byte(pick_escape());
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        set_newline(1'b0);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_random(40);
        send_end();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        // every input known from time zero, reset held low at the start
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_gaps       = 1'b0;
        sink_gaps      = 1'b0;
        scan_mode      = SCAN_TEXT;
        in_bracket     = 1'b0;
        bracket_filled = 1'b0;
        newline_on     = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_escapes();
        test_brackets();
        test_end_marker();
        test_random_phases();
        test_backpressure();
        test_full_rate();

        drain();
        $display("covered %0d input transfers, %0d result transfers, %0d class expansions",
                 n_sent, n_results, n_expansions);
        $display("with %0d end markers and %0d cycles of stalled input", n_ends, n_input_stalls);
        if (n_errors == 0 && pending_bytes.size() == 0) begin
            $display("regex_class_escape_expander: match");
        end else begin
            $display("regex_class_escape_expander: mismatch");
        end
        $finish;
    end

endmodule
